// ===== rtl/sap_pkg.sv =====
`default_nettype none
package sap_pkg;
  localparam int unsigned CoordW = 33;
  localparam int unsigned ExtW   = 31;
  localparam int unsigned IdW    = 3;

  typedef enum logic [2:0] {
    StIdle,
    StSort,
    StScanLoad,
    StScanStep,
    StAlign,
    StEmit
  } sap_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] bottom;
    logic [ExtW-1:0]          width;
    logic [ExtW-1:0]          height;
    logic [IdW-1:0]           id;
  } box_t;

  // Control from the sequencer to the cell row.
  typedef struct packed {
    logic load;   // write new box at fill position
    logic sort;   // one odd/even transposition step
    logic phase;  // 0 = even pairs, 1 = odd pairs
    logic shift;  // rotate row toward cell 0
  } row_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/sweep_and_prune_broad_phase_unit.sv =====
`default_nettype none
// Channel   Dir  Content
// s_axis    in   tdata: pos_x, pos_y, hull_offset_x, hull_offset_y, extent_x, extent_y
//                tuser: op
// m_axis    out  tdata: first_body, second_body, pair_valid, dropped; tlast: last
//
// A load writes the next free cell. A sweep request sorts the filled cells in
// N odd/even transposition steps, then scans: the head box (first in x order)
// is held while the row rotates past it, one candidate per cycle unless the
// scan is stalled on output; after the inner scan the row rotates on until the
// next box in order is at the head. Results wait in one output register; the
// scan stalls when a pair must go out while it is full and not taken.
// Input is ready only in idle.
// Reset clears count, overflow, state and output valid; cells are not reset.
module sweep_and_prune_broad_phase_unit #(
  parameter int unsigned MAX_BODIES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] hull_offset_x, [127:96] hull_offset_y,
  // [158:128] extent_x, [189:159] extent_y, zero fill to 192
  input  wire logic [191:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,   // [0] op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [2:0] first_body, [5:3] second_body, [6] pair_valid, [7] dropped
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tlast    // last
);
  import sap_pkg::*;
  localparam int unsigned N  = MAX_BODIES;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned IW = $clog2(N);

  sap_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;      // stored boxes
  logic [CW-1:0] i_q, i_d;          // outer position
  logic [CW-1:0] j_q, j_d;          // inner position / sort step
  logic [IW-1:0] hp_q, hp_d;        // sorted position now at the head
  logic [IW-1:0] hp_inc;
  logic          ovf_q, ovf_d;
  box_t          a_q, a_d;          // held head box
  logic          pend_q, pend_d;    // a pair waiting for its successor
  logic [IdW-1:0] pa_q, pa_d, pb_q, pb_d;

  logic          ov_q, ov_d;
  logic [7:0]    od_q, od_d;
  logic          ol_q, ol_d;

  row_ctrl_t ctrl;
  box_t      nb, head;

  logic signed [CoordW:0] x_end, a_top, b_top;
  logic hit, brk, out_free;

  assign nb.left   = CoordW'($signed(s_axis_tdata[31:0])) + CoordW'($signed(s_axis_tdata[95:64]));
  assign nb.bottom = CoordW'($signed(s_axis_tdata[63:32])) + CoordW'($signed(s_axis_tdata[127:96]));
  assign nb.width  = s_axis_tdata[158:128];
  assign nb.height = s_axis_tdata[189:159];
  assign nb.id     = IdW'(cnt_q);

  sap_row #(.N(N)) u_row (
    .clk_i(clk_i), .ctrl_i(ctrl), .fill_i(cnt_q), .new_i(nb), .head_o(head)
  );

  // head is the candidate box b during the scan
  assign x_end = (CoordW+1)'(a_q.left) + $signed({2'b0, a_q.width});
  assign a_top = (CoordW+1)'(a_q.bottom) + $signed({2'b0, a_q.height});
  assign b_top = (CoordW+1)'(head.bottom) + $signed({2'b0, head.height});
  assign brk   = x_end < (CoordW+1)'(head.left);
  assign hit   = (a_q.bottom < head.bottom) ? ((CoordW+1)'(head.bottom) <= a_top)
                                            : ((CoordW+1)'(a_q.bottom) <= b_top);
  assign out_free = !ov_q || m_axis_tready;
  assign hp_inc   = (hp_q == IW'(N - 1)) ? '0 : hp_q + 1'b1;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; hp_d = hp_q;
    ovf_d = ovf_q; a_d = a_q; pend_d = pend_q; pa_d = pa_q; pb_d = pb_q;
    ov_d = ov_q && !m_axis_tready; od_d = od_q; ol_d = ol_q;
    ctrl = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            if (cnt_q < CW'(N)) begin
              ctrl.load = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            j_d = '0; pend_d = 1'b0; i_d = '0; hp_d = '0;
            state_d = StSort;
          end
        end
      end
      StSort: begin
        ctrl.sort  = 1'b1;
        ctrl.phase = j_q[0];
        j_d = j_q + 1'b1;
        if (j_q == CW'(N - 1)) state_d = StScanLoad;
      end
      StScanLoad: begin
        // head is the box at sorted position i; hold it, rotate once
        if (i_q + 1'b1 >= cnt_q) begin
          state_d = StEmit;
        end else begin
          a_d = head; ctrl.shift = 1'b1; hp_d = hp_inc; j_d = i_q + 1'b1;
          state_d = StScanStep;
        end
      end
      StScanStep: begin
        // head is the box at sorted position j
        if (j_q >= cnt_q || brk) begin
          state_d = StAlign;
        end else if (!(hit && pend_q) || out_free) begin
          if (hit) begin
            if (pend_q) begin
              ov_d = 1'b1; od_d = {ovf_q, 1'b1, pb_q, pa_q}; ol_d = 1'b0;
            end
            pend_d = 1'b1; pa_d = a_q.id; pb_d = head.id;
          end
          ctrl.shift = 1'b1; hp_d = hp_inc; j_d = j_q + 1'b1;
        end
      end
      StAlign: begin
        // rotate until the box at position i+1 is at the head
        if (CW'(hp_q) == i_q + 1'b1) begin
          i_d = i_q + 1'b1;
          state_d = StScanLoad;
        end else begin
          ctrl.shift = 1'b1; hp_d = hp_inc;
        end
      end
      StEmit: begin
        if (out_free) begin
          ov_d = 1'b1; ol_d = 1'b1;
          if (pend_q) od_d = {ovf_q, 1'b1, pb_q, pa_q};
          else        od_d = {ovf_q, 1'b0, IdW'(0), IdW'(0)};
          cnt_d = '0; ovf_d = 1'b0; pend_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; ovf_q <= 1'b0; ov_q <= 1'b0;
      pend_q <= 1'b0; i_q <= '0; j_q <= '0; hp_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; ov_q <= ov_d;
      pend_q <= pend_d; i_q <= i_d; j_q <= j_d; hp_q <= hp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; pa_q <= pa_d; pb_q <= pb_d; od_q <= od_d; ol_q <= ol_d;
  end
endmodule
`default_nettype wire

// ===== rtl/sap_cell.sv =====
`default_nettype none
// One storage cell of the row. Holds one box; takes a new box on a load, or a
// neighbor's box on a sort swap or a shift.
module sap_cell (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire sap_pkg::box_t d_i,
  output sap_pkg::box_t      q_o
);
  import sap_pkg::*;
  box_t box_q;
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      box_q <= d_i;
    end
  end
  assign q_o = box_q;
endmodule
`default_nettype wire

// ===== rtl/sap_row.sv =====
`default_nettype none
// Row of cells. Sort is odd/even transposition on neighbors (stable: swap
// only on strictly greater left), limited to the filled cells. Shift rotates
// by one toward cell 0.
module sap_row #(
  parameter int unsigned N = 8
) (
  input  wire logic              clk_i,
  input  wire sap_pkg::row_ctrl_t ctrl_i,
  input  wire logic [$clog2(N+1)-1:0] fill_i,
  input  wire sap_pkg::box_t      new_i,
  output sap_pkg::box_t           head_o
);
  import sap_pkg::*;
  localparam int unsigned IW = $clog2(N);
  box_t q [N];
  box_t d [N];
  logic we [N];

  for (genvar c = 0; c < N; c++) begin : g_cell
    always_comb begin
      d[c]  = q[c];
      we[c] = 1'b0;
      if (ctrl_i.load) begin
        we[c] = (fill_i[IW-1:0] == IW'(c)) && (fill_i < ($clog2(N+1))'(N));
        d[c]  = new_i;
      end else if (ctrl_i.shift) begin
        we[c] = 1'b1;
        d[c]  = q[(c + 1) % N];
      end else if (ctrl_i.sort) begin
        // pair (p, p+1) with p parity == phase, both cells filled
        if ((c % 2) == int'(ctrl_i.phase) && c + 1 < N && c + 1 < int'(fill_i)) begin
          we[c] = 1'b1;
          if (q[c].left > q[(c + 1) % N].left) d[c] = q[(c + 1) % N];
        end else if (c > 0 && ((c - 1) % 2) == int'(ctrl_i.phase) &&
                     c < int'(fill_i)) begin
          we[c] = 1'b1;
          if (q[(c + N - 1) % N].left > q[c].left) d[c] = q[(c + N - 1) % N];
        end
      end
    end
    sap_cell u_cell (.clk_i(clk_i), .we_i(we[c]), .d_i(d[c]), .q_o(q[c]));
  end

  assign head_o = q[0];
endmodule
`default_nettype wire

// ===== tb/sv/sweep_and_prune_broad_phase_unit_test.sv =====
`timescale 1ns / 1ps
module sweep_and_prune_broad_phase_unit_test;
  import sap_pkg::*;

  localparam int unsigned NBodies  = 8;
  localparam int unsigned CycLimit = 400000;

  typedef enum logic {OpLoad = 1'b0, OpSweep = 1'b1} op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] off_x;
    logic [31:0] off_y;
    logic [30:0] ext_x;
    logic [30:0] ext_y;
  } box_req_t;

  typedef struct packed {
    logic [2:0] first_body;
    logic [2:0] second_body;
    logic       pair_valid;
    logic       last;
    logic       dropped;
  } pair_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;

  sweep_and_prune_broad_phase_unit #(.MAX_BODIES(NBodies)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: exact 33-bit edges
  logic signed [32:0] pl_left [NBodies];
  logic signed [32:0] pl_bot  [NBodies];
  logic [30:0]        pl_w    [NBodies];
  logic [30:0]        pl_h    [NBodies];
  int unsigned        pl_count = 0;
  logic               pl_ovf = 1'b0;

  box_req_t  pending_reqs[$];
  pair_rsp_t expected_pairs[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  // Apply one accepted request to the predictor and queue its pairs.
  task automatic predict_pairs(input box_req_t r);
    int unsigned ord[NBodies];
    int unsigned n, i, j, a, b, v, hits;
    logic signed [33:0] x_end, ay_top, by_top;
    logic ov;
    pair_rsp_t p;
    if (r.op == OpLoad) begin
      if (pl_count >= NBodies) begin
        pl_ovf = 1'b1;
      end else begin
        pl_left[pl_count] = $signed(r.pos_x) + $signed(r.off_x);
        pl_bot[pl_count]  = $signed(r.pos_y) + $signed(r.off_y);
        pl_w[pl_count] = r.ext_x;
        pl_h[pl_count] = r.ext_y;
        pl_count++;
      end
      return;
    end
    n = pl_count;
    for (i = 0; i < n; i++) begin
      v = i;
      j = i;
      while (j > 0 && pl_left[ord[j-1]] > pl_left[v]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    hits = 0;
    for (i = 0; i + 1 < n; i++) begin
      a = ord[i];
      x_end  = pl_left[a] + $signed({1'b0, pl_w[a]});
      ay_top = pl_bot[a] + $signed({1'b0, pl_h[a]});
      for (j = i + 1; j < n; j++) begin
        b = ord[j];
        if (x_end < pl_left[b]) break;
        by_top = pl_bot[b] + $signed({1'b0, pl_h[b]});
        if (pl_bot[a] < pl_bot[b]) ov = (pl_bot[b] <= ay_top);
        else ov = (pl_bot[a] <= by_top);
        if (ov) begin
          p = '{first_body: a[2:0], second_body: b[2:0], pair_valid: 1'b1,
                last: 1'b0, dropped: pl_ovf};
          expected_pairs = {expected_pairs, p};
          hits++;
        end
      end
    end
    if (hits == 0) begin
      p = '{first_body: 3'd0, second_body: 3'd0, pair_valid: 1'b0,
            last: 1'b1, dropped: pl_ovf};
      expected_pairs = {expected_pairs, p};
    end else begin
      expected_pairs[expected_pairs.size() - 1].last = 1'b1;
    end
    pl_count = 0;
    pl_ovf = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(input bit wide);
    // mostly a small window so boxes touch; sometimes the full range
    if (wide) return $urandom;
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic box_req_t mk_load(input bit wide);
    box_req_t r;
    r.op = OpLoad;
    r.pos_x = rand_coord(wide);
    r.pos_y = rand_coord(wide);
    r.off_x = wide ? $urandom : $urandom_range(0, 32'h0001_0000);
    r.off_y = wide ? $urandom : $urandom_range(0, 32'h0001_0000);
    r.ext_x = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0003_0000));
    r.ext_y = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0003_0000));
    return r;
  endfunction

  function automatic box_req_t mk_box(input logic [31:0] px, py, ox, oy,
                                      input logic [30:0] ex, ey);
    box_req_t r;
    r = '{op: OpLoad, pos_x: px, pos_y: py, off_x: ox, off_y: oy, ext_x: ex, ext_y: ey};
    return r;
  endfunction

  function automatic box_req_t mk_sweep();
    box_req_t r;
    r = mk_load(1'b1);  // payload is ignored, but randomized anyway
    r.op = OpSweep;
    return r;
  endfunction

  initial begin : stimulus
    int unsigned nb, k;
    // empty sweep
    pending_reqs = {pending_reqs, mk_sweep()};
    // one box only
    pending_reqs = {pending_reqs, mk_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                         32'h7fff_ffff, 31'h7fff_ffff, 31'h0)};
    pending_reqs = {pending_reqs, mk_sweep()};
    // equal left edges, touching in y at the bound, extremes of sums
    pending_reqs = {pending_reqs, mk_box(32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 31'h0001_0000)};
    pending_reqs = {pending_reqs, mk_box(32'h0, 32'h0001_0000, 32'h0, 32'h0, 31'h0, 31'h0)};
    pending_reqs = {pending_reqs, mk_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                         32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff)};
    pending_reqs = {pending_reqs, mk_box(32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0,
                                         31'h0, 31'h0)};
    pending_reqs = {pending_reqs, mk_sweep()};
    // full store then overflow: ten loads of identical boxes
    for (k = 0; k < 10; k++)
      pending_reqs = {pending_reqs, mk_box(32'h0, 32'h0, 32'h0, 32'h0, 31'h10, 31'h10)};
    pending_reqs = {pending_reqs, mk_sweep()};
    // random frames
    while (pending_reqs.size() < 330) begin
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
      for (k = 0; k < nb; k++)
        pending_reqs = {pending_reqs, mk_load($urandom_range(0, 5) == 0)};
      pending_reqs = {pending_reqs, mk_sweep()};
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pairs(pending_reqs.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_reqs[0].op;
          s_axis_tdata  <= {2'b00, pending_reqs[0].ext_y, pending_reqs[0].ext_x,
                            pending_reqs[0].off_y, pending_reqs[0].off_x,
                            pending_reqs[0].pos_y, pending_reqs[0].pos_x};
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // long receiver hold-off once, early, so the block backs up
  initial begin : long_stall
    int unsigned n;
    @(posedge rst_ni);
    hold_off = 1'b1;
    n = 0;
    while (n < 600) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

  // monitor: receiver stall pattern and checking
  pair_rsp_t got, want;
  int unsigned phase_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      phase_cnt <= phase_cnt + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{first_body: m_axis_tdata[2:0], second_body: m_axis_tdata[5:3],
                pair_valid: m_axis_tdata[6], last: m_axis_tlast,
                dropped: m_axis_tdata[7]};
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_pairs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      // stretches of full speed alternating with a random pattern
      if (hold_off) m_axis_tready <= 1'b0;
      else if (phase_cnt[9:8] == 2'b00) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : finish_ctl
    int unsigned tail;
    @(posedge rst_ni);
    while (!(stim_done && expected_pairs.size() == 0) && cycles < CycLimit)
      @(posedge clk_i);
    tail = 0;
    while (tail < 100 && cycles < CycLimit) begin
      @(posedge clk_i);
      tail++;
    end
    if (cycles >= CycLimit) begin
      $display("Test completed with failures");
    end else if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
